/* hdl/fpc_pkg.sv */
// Shared types and constants for the flow pair packet counter.
`default_nettype none
package fpc_pkg;

   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned SLOT_W  = 10;  // holds any slot number up to 1023
   localparam int unsigned IDX_W   = 6;   // width of the reported entry index
   localparam int unsigned STAT_W  = 2;

   localparam logic [ADDR_W-1:0]  EXCL_RESET = 32'hC0A8_3801;  // 192.168.56.1
   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

   localparam logic [STAT_W-1:0] ST_HIT     = 2'd0;
   localparam logic [STAT_W-1:0] ST_NEW     = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] ST_IGNORED = 2'd3;

   // Search token handed from cell to cell.
   typedef struct packed {
      logic               active;
      logic               found;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] count;
   } token_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
      sat_inc = (value == COUNT_MAX) ? value : value + COUNT_W'(1);
   endfunction

endpackage
`default_nettype wire

/* hdl/fpc_cell.sv */
// One table slot: holds an address pair and its count, passes the search token on.
`default_nettype none
module fpc_cell #(
   parameter int unsigned CELL_INDEX = 0
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         live,
   input  wire                         wr_en,
   input  wire [fpc_pkg::ADDR_W-1:0]   key_src,
   input  wire [fpc_pkg::ADDR_W-1:0]   key_dst,
   input  fpc_pkg::token_type          tok_in,
   output fpc_pkg::token_type          tok_out
);
   import fpc_pkg::*;

   logic [ADDR_W-1:0]  src_ff, src_in;
   logic [ADDR_W-1:0]  dst_ff, dst_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   token_type          tok_ff, tok_next_in;
   logic               match;
   logic               hit;
   logic [COUNT_W-1:0] bumped;

   assign match  = live && (src_ff == key_src) && (dst_ff == key_dst);
   assign hit    = tok_in.active && !tok_in.found && match;
   assign bumped = sat_inc(count_ff);

   always_comb begin
      src_in      = src_ff;
      dst_in      = dst_ff;
      count_in    = count_ff;
      tok_next_in = tok_in;
      if (wr_en) begin
         src_in   = key_src;
         dst_in   = key_dst;
         count_in = COUNT_W'(1);
      end else if (hit) begin
         count_in = bumped;
      end
      if (hit) begin
         tok_next_in.found = 1'b1;
         tok_next_in.slot  = SLOT_W'(CELL_INDEX);
         tok_next_in.count = bumped;
      end
   end

   always_ff @(posedge clock) begin
      src_ff   <= src_in;
      dst_ff   <= dst_in;
      count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_next_in;
      end
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

/* hdl/flow_pair_packet_counter_core.sv */
// Top level of the flow pair packet counter: controller and chain of table cells.
// Timing: an ignored request skips the search and goes straight to the result
//   stage; for a counted one the result is formed once the search token, walking
//   one cell per cycle down the chain of slots, leaves the last cell.
// Throughput: one request in flight; the next is taken only after the last result is published.
// Reset: empties the table (occupancy 0), loads the excluded address default.
`default_nettype none
module flow_pair_packet_counter_core #(
   parameter int unsigned TABLE_ENTRIES = 64
) (
   input  wire                          clock,
   input  wire                          reset,
   // request channel
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [fpc_pkg::ADDR_W-1:0]    req_src_addr,
   input  wire [fpc_pkg::ADDR_W-1:0]    req_dst_addr,
   input  wire                          req_header_ok,
   // result channel
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [fpc_pkg::STAT_W-1:0]   rsp_status,
   output logic [fpc_pkg::IDX_W-1:0]    rsp_entry_index,
   output logic [fpc_pkg::COUNT_W-1:0]  rsp_packet_count,
   // configuration
   input  wire                          csr_write_enable,
   input  wire [fpc_pkg::ADDR_W-1:0]    csr_write_data
);
   import fpc_pkg::*;

   localparam int unsigned OCC_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WAIT = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  excl_ff, excl_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [ADDR_W-1:0]  key_src_ff, key_src_in;
   logic [ADDR_W-1:0]  key_dst_ff, key_dst_in;
   logic               inject_ff, inject_in;
   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic [SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               accept;
   logic               ignored;
   logic               table_full;
   logic               slot_free;
   logic               write_go;
   token_type          tok [0:TABLE_ENTRIES];

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign ignored    = !req_header_ok || (req_src_addr == excl_ff) ||
                       (req_dst_addr == excl_ff);
   assign table_full = (occ_ff == OCC_W'(TABLE_ENTRIES));
   // output register is free when empty or being drained this cycle
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign write_go   = (state_ff == S_DONE) && slot_free && (res_status_ff == ST_NEW);

   // Launch the search token into the head of the chain.
   always_comb begin
      tok[0]        = '0;
      tok[0].active = inject_ff;
   end

   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      fpc_cell #(
         .CELL_INDEX(k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .live    (occ_ff > OCC_W'(k)),
         .wr_en   (write_go && (occ_ff == OCC_W'(k))),
         .key_src (key_src_ff),
         .key_dst (key_dst_ff),
         .tok_in  (tok[k]),
         .tok_out (tok[k+1])
      );
   end

   always_comb begin
      state_in      = state_ff;
      excl_in       = csr_write_enable ? csr_write_data : excl_ff;
      occ_in        = occ_ff;
      key_src_in    = key_src_ff;
      key_dst_in    = key_dst_ff;
      inject_in     = 1'b0;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_src_in = req_src_addr;
               key_dst_in = req_dst_addr;
               if (ignored) begin
                  // skip the search, answer straight away
                  res_status_in = ST_IGNORED;
                  res_slot_in   = '0;
                  res_count_in  = '0;
                  state_in      = S_DONE;
               end else begin
                  inject_in = 1'b1;
                  state_in  = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            // hold until the token leaves the last cell
            if (tok[TABLE_ENTRIES].active) begin
               if (tok[TABLE_ENTRIES].found) begin
                  res_status_in = ST_HIT;
                  res_slot_in   = tok[TABLE_ENTRIES].slot;
                  res_count_in  = tok[TABLE_ENTRIES].count;
               end else if (table_full) begin
                  res_status_in = ST_FULL;
                  res_slot_in   = '0;
                  res_count_in  = '0;
               end else begin
                  res_status_in = ST_NEW;
                  res_slot_in   = SLOT_W'(occ_ff);
                  res_count_in  = COUNT_W'(1);
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // publish the result and append the new pair in the same cycle
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_count_in  = res_count_ff;
               if (res_status_ff == ST_NEW) begin
                  occ_in = occ_ff + OCC_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         excl_ff      <= EXCL_RESET;
         occ_ff       <= '0;
         inject_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         excl_ff      <= excl_in;
         occ_ff       <= occ_in;
         inject_ff    <= inject_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_src_ff    <= key_src_in;
      key_dst_ff    <= key_dst_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_index  = rsp_slot_ff[IDX_W-1:0];  // slot number masked to 6 bits
   assign rsp_packet_count = rsp_count_ff;

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the flow pair packet counter core.
module testbench;
   import fpc_pkg::*;

   localparam int unsigned SLOTS       = 64;
   // A counted request walks the whole chain of slots before it answers.
   localparam int unsigned LATENCY     = SLOTS + 4;
   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned POOL_PAIRS  = 96;  // more pairs than slots, so the table fills

   typedef struct packed {
      logic [ADDR_W-1:0] src;
      logic [ADDR_W-1:0] dst;
      logic              hdr;
   } packet_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [IDX_W-1:0]   index;
      logic [COUNT_W-1:0] count;
   } tally_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [ADDR_W-1:0]   req_src_addr     = '0;
   logic [ADDR_W-1:0]   req_dst_addr     = '0;
   logic                req_header_ok    = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [IDX_W-1:0]    rsp_entry_index;
   logic [COUNT_W-1:0]  rsp_packet_count;
   logic                csr_write_enable = 1'b0;
   logic [ADDR_W-1:0]   csr_write_data   = '0;

   // Stimulus and expectation stores.
   packet_type pending_packets[$];
   tally_type  expected_tallies[$];
   packet_type next_packet;
   tally_type  oldest_tally;

   // Our own copy of the flow table and the excluded address.
   logic [ADDR_W-1:0]  flow_src[SLOTS];
   logic [ADDR_W-1:0]  flow_dst[SLOTS];
   logic [COUNT_W-1:0] flow_count[SLOTS];
   int unsigned        flows_used         = 0;
   logic [ADDR_W-1:0]  excluded_addr_copy = EXCL_RESET;

   // Pairs that random traffic keeps returning to, so most requests hit.
   logic [ADDR_W-1:0]  pool_src[POOL_PAIRS];
   logic [ADDR_W-1:0]  pool_dst[POOL_PAIRS];

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned error_count    = 0;
   int unsigned quiet_cycles   = 0;

   flow_pair_packet_counter_core #(
      .TABLE_ENTRIES(SLOTS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_src_addr     (req_src_addr),
      .req_dst_addr     (req_dst_addr),
      .req_header_ok    (req_header_ok),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_packet_count (rsp_packet_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Count one packet against the table copy and return the result it must produce.
   function automatic tally_type count_packet(input packet_type pkt);
      tally_type   res;
      int unsigned k;
      res        = '0;
      res.status = ST_IGNORED;
      // Drop packets without a transport header or touching the excluded address.
      if (!pkt.hdr || pkt.src == excluded_addr_copy || pkt.dst == excluded_addr_copy)
         return res;
      for (k = 0; k < flows_used; k++) begin
         if (flow_src[k] == pkt.src && flow_dst[k] == pkt.dst) begin
            // Hold the count once it has saturated.
            if (flow_count[k] != COUNT_MAX)
               flow_count[k] = flow_count[k] + 1'b1;
            res.status = ST_HIT;
            res.index  = k[IDX_W-1:0];
            res.count  = flow_count[k];
            return res;
         end
      end
      if (flows_used >= SLOTS) begin
         res.status = ST_FULL;
         return res;
      end
      flow_src[flows_used]   = pkt.src;
      flow_dst[flows_used]   = pkt.dst;
      flow_count[flows_used] = 1;
      res.status = ST_NEW;
      res.index  = flows_used[IDX_W-1:0];
      res.count  = 1;
      flows_used++;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic void add_packet(input logic [ADDR_W-1:0] src,
                                      input logic [ADDR_W-1:0] dst, input logic hdr);
      packet_type pkt;
      pkt.src = src;
      pkt.dst = dst;
      pkt.hdr = hdr;
      pending_packets.push_back(pkt);
   endfunction

   // Queue random requests until the given number of them will be counted;
   // ignored requests ride along but do not advance the total.
   task automatic queue_random(input int unsigned target);
      int unsigned counted;
      int unsigned pick;
      int unsigned slot;
      packet_type  pkt;
      counted = 0;
      while (counted < target) begin
         pick     = $urandom_range(99);
         slot     = $urandom_range(POOL_PAIRS - 1);
         pkt.src  = pool_src[slot];
         pkt.dst  = pool_dst[slot];
         pkt.hdr  = 1'b1;
         if (pick < 8) begin
            // noise: no transport header, known pair or garbage addresses
            pkt.hdr = 1'b0;
            if ($urandom_range(1)) begin
               pkt.src = $urandom;
               pkt.dst = $urandom;
            end
         end else if (pick < 16) begin
            // touch the excluded address from either side
            pkt.hdr = 1'($urandom_range(1));
            if ($urandom_range(1))
               pkt.src = excluded_addr_copy;
            else
               pkt.dst = excluded_addr_copy;
         end else if (pick < 24) begin
            // fresh pair: new entry while there is room, dropped once full
            pkt.src = $urandom;
            pkt.dst = $urandom;
         end
         pending_packets.push_back(pkt);
         if (pkt.hdr && pkt.src != excluded_addr_copy && pkt.dst != excluded_addr_copy)
            counted++;
      end
   endtask

   // Hold until every queued request is accepted and every result has come back.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_packets.size() != 0 || req_valid || expected_tallies.size() != 0);
   endtask

   // Write the excluded address; only called while the block is idle.
   task automatic write_excluded(input logic [ADDR_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      excluded_addr_copy = value;
      @(negedge clock);
   endtask

   // Request driver: record the prediction for each accepted request, then
   // present the next one when the sender is not idling this cycle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_tallies.push_back(count_packet('{src: req_src_addr,
                                                      dst: req_dst_addr,
                                                      hdr: req_header_ok}));
         end
         // Advance only when the channel is empty or its request leaves now.
         if (!req_valid || req_ready) begin
            if (pending_packets.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_packet = pending_packets.pop_front();
               req_valid     <= 1'b1;
               req_src_addr  <= next_packet.src;
               req_dst_addr  <= next_packet.dst;
               req_header_ok <= next_packet.hdr;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tallies.size() == 0) begin
               $display("%0t: result with none expected, status %0d index %0d count %0h",
                        $time, rsp_status, rsp_entry_index, rsp_packet_count);
               error_count++;
            end else begin
               oldest_tally = expected_tallies.pop_front();
               check_field("status", 32'(oldest_tally.status), 32'(rsp_status));
               check_field("entry_index", 32'(oldest_tally.index), 32'(rsp_entry_index));
               check_field("packet_count", oldest_tally.count, rsp_packet_count);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: end the run when no handshake happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int unsigned k;
      // Build the pair pool: extremes first, then pairs sharing a source.
      pool_src[0] = '0;
      pool_dst[0] = '1;
      pool_src[1] = '1;
      pool_dst[1] = '0;
      for (k = 2; k < POOL_PAIRS; k++) begin
         pool_src[k] = (k % 4 == 0) ? pool_src[k - 1] : $urandom;
         pool_dst[k] = $urandom;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Phase one: slow receiver. Directed requests run with the reset
      // value of the excluded address still in place.
      send_idle_pct  = 19;
      recv_stall_pct = 68;
      add_packet('0, '0, 1'b0);                     // no header
      add_packet('1, '1, 1'b0);                     // no header, all ones
      add_packet(EXCL_RESET, 32'h1, 1'b1);          // excluded source
      add_packet(32'h2, EXCL_RESET, 1'b1);          // excluded destination
      add_packet(EXCL_RESET, EXCL_RESET, 1'b0);     // header check comes first
      add_packet('0, '0, 1'b1);                     // new pair in slot 0
      add_packet('0, '0, 1'b1);                     // hit
      add_packet('1, '1, 1'b1);
      add_packet('0, '1, 1'b1);
      add_packet('1, '0, 1'b1);
      add_packet('0, '0, 1'b1);
      add_packet('1, '0, 1'b1);
      add_packet(32'h0A00_0001, 32'h0A00_0002, 1'b1);
      add_packet(32'h0A00_0002, 32'h0A00_0001, 1'b1); // reversed direction is its own pair
      add_packet(32'h0000_0005, 32'h0000_0005, 1'b1); // source equals destination
      add_packet(EXCL_RESET ^ 32'h1, 32'h3, 1'b1);    // one bit off the excluded address
      add_packet('0, '0, 1'b0);                       // known pair without header stays put
      add_packet('0, '0, 1'b1);
      add_packet(32'h0A00_0001, 32'h0A00_0002, 1'b1);
      wait_drained();

      write_excluded('1);
      queue_random(140);
      wait_drained();

      // Phase two: slow sender, excluded address at zero.
      send_idle_pct  = 68;
      recv_stall_pct = 19;
      write_excluded('0);
      queue_random(150);
      wait_drained();

      // Phase three: no idling on either side, random excluded address.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_excluded($urandom);
      queue_random(150);
      wait_drained();

      // Let any stray result show up before the verdict.
      repeat (2 * LATENCY) @(posedge clock);
      if (error_count == 0 && expected_tallies.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* sim.f */
hdl/fpc_pkg.sv
hdl/fpc_cell.sv
hdl/flow_pair_packet_counter_core.sv
tb/sv/testbench.sv
